// File: hw/rtl/bsr_pkg.sv
// Package for the barcode stable rank block: payload structs, the sequencer
// state type, the compare unit result and shared constants. No dependencies.
package bsr_pkg;

  localparam int unsigned ValueW         = 32;
  localparam int unsigned RankW          = 6;
  localparam int unsigned MaxBarsDefault = 32;

  typedef struct packed {
    logic [ValueW-1:0] birth_value;
    logic [ValueW-1:0] death_value;
    logic              death_is_finite;
    logic              last_bar;
  } bar_t;

  typedef struct packed {
    logic [ValueW-1:0] step_position;
    logic [RankW-1:0]  rank_value;
    logic              last_point;
    logic              overflowed;
  } point_t;

  // Result of the shared compare unit for operands a and b.
  typedef struct packed {
    logic              gt;    // a > b
    logic              eq;    // a == b
    logic [ValueW-1:0] diff;  // a - b, saturated to zero when b > a
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_EMIT0,
    ST_SCAN,
    ST_TAIL
  } bsr_state_e;

endpackage

// File: hw/rtl/barcode_stable_rank.sv
// Barcode stable rank, top level. Uses bsr_pkg and bsr_alu.
// An infinite, dropped or first finite bar is taken without insertion; any other finite bar
// is inserted into the store in ascending order, one store shift per cycle.
// After the last bar it emits the point at zero, then scans any finite lifetimes in the store.
// Results are registered before they reach the ports; the receiver cannot stall them.
// Reset (rst_ni low, asynchronous) clears the sequencer and counters; the store is not cleared.
module barcode_stable_rank import bsr_pkg::*; #(
  parameter int unsigned MAX_BARS = MaxBarsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  output logic   busy_o,
  input  bar_t   bar_i,
  output logic   point_valid_o,
  output point_t point_o
);

  // Counters hold 0..MAX_BARS; store indexes cover 0..MAX_BARS-1.
  localparam int unsigned CntW = $clog2(MAX_BARS + 1);
  localparam int unsigned IdxW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

  bsr_state_e state_q, state_d;

  logic [CntW-1:0]   fin_cnt_q, fin_cnt_d;
  logic [CntW-1:0]   bar_cnt_q, bar_cnt_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [CntW-1:0]   j_q, j_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   surv_q, surv_d;
  logic              first_q, first_d;
  logic [ValueW-1:0] key_q, key_d;
  logic [ValueW-1:0] prev_q, prev_d;
  logic              pt_valid_q, pt_valid_d;
  point_t            pt_q, pt_d;

  // Store of finite lifetimes, kept in ascending order by insertion.
  logic [ValueW-1:0] store_mem [MAX_BARS];
  logic              wr_en, rd_en;
  logic [IdxW-1:0]   wr_addr, rd_addr;
  logic [ValueW-1:0] wr_data, rd_data_q;

  logic [ValueW-1:0] alu_a, alu_b;
  cmp_res_t          alu_res;

  logic            accept, room;
  logic [CntW-1:0] fin_m1, j_m1, j_m2, idx_p1, surv_m1, bar_p1, fin_p1;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign room    = (bar_cnt_q < CntW'(MAX_BARS));
  assign fin_m1  = fin_cnt_q - CntW'(1);
  assign fin_p1  = fin_cnt_q + CntW'(1);
  assign bar_p1  = bar_cnt_q + CntW'(1);
  assign j_m1    = j_q - CntW'(1);
  assign j_m2    = j_q - CntW'(2);
  assign idx_p1  = idx_q + CntW'(1);
  assign surv_m1 = surv_q - CntW'(1);

  // The one compare unit serves three purposes. On an incoming bar it forms
  // the saturated lifetime, during insertion it decides whether a stored
  // entry moves up, and during the scan it detects a new distinct lifetime.
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        alu_a = bar_i.death_value;
        alu_b = bar_i.birth_value;
      end
      ST_SCAN: begin
        alu_a = rd_data_q;
        alu_b = prev_q;
      end
      default: begin
        alu_a = rd_data_q;
        alu_b = key_q;
      end
    endcase
  end

  bsr_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (room && bar_i.death_is_finite && (fin_cnt_q != '0)) begin
            state_d = ST_INS;
          end else if (bar_i.last_bar) begin
            state_d = ST_EMIT0;
          end
        end
      end
      ST_INS: begin
        if (alu_res.gt) begin
          if (j_q == CntW'(1)) begin
            state_d = ST_PUT;
          end
        end else begin
          state_d = last_q ? ST_EMIT0 : ST_IDLE;
        end
      end
      ST_PUT: begin
        state_d = last_q ? ST_EMIT0 : ST_IDLE;
      end
      ST_EMIT0: begin
        state_d = (fin_cnt_q == '0) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_q == fin_m1) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath controls and register updates.
  always_comb begin
    fin_cnt_d  = fin_cnt_q;
    bar_cnt_d  = bar_cnt_q;
    ovf_d      = ovf_q;
    last_d     = last_q;
    j_d        = j_q;
    idx_d      = idx_q;
    surv_d     = surv_q;
    first_d    = first_q;
    key_d      = key_q;
    prev_d     = prev_q;
    pt_valid_d = 1'b0;
    pt_d       = pt_q;
    wr_en      = 1'b0;
    wr_addr    = j_q[IdxW-1:0];
    wr_data    = key_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = bar_i.last_bar;
          key_d  = alu_res.diff;
          j_d    = fin_cnt_q;
          if (room) begin
            bar_cnt_d = bar_p1;
            if (bar_i.death_is_finite) begin
              fin_cnt_d = fin_p1;
              if (fin_cnt_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = alu_res.diff;
              end else begin
                rd_en   = 1'b1;
                rd_addr = fin_m1[IdxW-1:0];
              end
            end
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_INS: begin
        // rd_data_q holds entry j-1; a larger entry moves up to slot j.
        wr_en = 1'b1;
        if (alu_res.gt) begin
          wr_data = rd_data_q;
          j_d     = j_m1;
          if (j_q != CntW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = j_m2[IdxW-1:0];
          end
        end
      end
      ST_PUT: begin
        wr_en = 1'b1;
      end
      ST_EMIT0: begin
        pt_valid_d       = 1'b1;
        pt_d.step_position = '0;
        pt_d.rank_value  = RankW'(bar_cnt_q);
        pt_d.last_point  = (fin_cnt_q == '0);
        pt_d.overflowed  = ovf_q;
        surv_d           = bar_cnt_q;
        idx_d            = '0;
        first_d          = 1'b1;
        if (fin_cnt_q == '0) begin
          fin_cnt_d = '0;
          bar_cnt_d = '0;
          ovf_d     = 1'b0;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_SCAN: begin
        // A change of value closes the step of the previous lifetime.
        if (!first_q && !alu_res.eq) begin
          pt_valid_d         = 1'b1;
          pt_d.step_position = prev_q;
          pt_d.rank_value    = RankW'(surv_q);
          pt_d.last_point    = 1'b0;
          pt_d.overflowed    = ovf_q;
        end
        prev_d  = rd_data_q;
        surv_d  = surv_m1;
        first_d = 1'b0;
        idx_d   = idx_p1;
        if (idx_q != fin_m1) begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[IdxW-1:0];
        end
      end
      ST_TAIL: begin
        pt_valid_d         = 1'b1;
        pt_d.step_position = prev_q;
        pt_d.rank_value    = RankW'(surv_q);
        pt_d.last_point    = 1'b1;
        pt_d.overflowed    = ovf_q;
        fin_cnt_d          = '0;
        bar_cnt_d          = '0;
        ovf_d              = 1'b0;
      end
      default: begin
        pt_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fin_cnt_q  <= '0;
      bar_cnt_q  <= '0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      j_q        <= '0;
      idx_q      <= '0;
      surv_q     <= '0;
      first_q    <= 1'b0;
      pt_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fin_cnt_q  <= fin_cnt_d;
      bar_cnt_q  <= bar_cnt_d;
      ovf_q      <= ovf_d;
      last_q     <= last_d;
      j_q        <= j_d;
      idx_q      <= idx_d;
      surv_q     <= surv_d;
      first_q    <= first_d;
      pt_valid_q <= pt_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prev_q <= prev_d;
    pt_q   <= pt_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign point_valid_o = pt_valid_q;
  assign point_o       = pt_q;

endmodule

// File: hw/rtl/bsr_alu.sv
// Shared compare and subtract unit of the barcode stable rank block.
// Depends on bsr_pkg for the value width and the result struct.
module bsr_alu import bsr_pkg::*; (
  input  logic [ValueW-1:0] a_i,
  input  logic [ValueW-1:0] b_i,
  output cmp_res_t          res_o
);

  logic [ValueW:0] sub;

  // The borrow bit of one subtraction gives the ordering and the saturation.
  assign sub        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.gt   = !sub[ValueW] && (sub[ValueW-1:0] != '0);
  assign res_o.eq   = (a_i == b_i);
  assign res_o.diff = sub[ValueW] ? '0 : sub[ValueW-1:0];

endmodule

// File: hw/rtl/bsr_checker.sv
// Port-level checks for the barcode stable rank block, bound to the top level.
// Depends on bsr_pkg for the payload structs.
module bsr_checker import bsr_pkg::*; #(
  parameter int unsigned MAX_BARS = MaxBarsDefault
) (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   start_i,
  input logic   busy_o,
  input bar_t   bar_i,
  input logic   point_valid_o,
  input point_t point_o
);

  // Only the final point of a function may show while the block is free.
  a_mid_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !point_o.last_point |-> busy_o)
    else $error("intermediate point while not busy");

  // The final point is never directly followed by another point.
  a_last_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && point_o.last_point |=> !point_valid_o)
    else $error("point right after final point");

  // A last bar always starts the emit sequence.
  a_last_bar_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && bar_i.last_bar |=> busy_o)
    else $error("last bar did not start emission");

  // No rank exceeds the capacity.
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o |-> (point_o.rank_value <= RankW'(MAX_BARS)))
    else $error("rank above capacity");

endmodule

bind barcode_stable_rank bsr_checker #(.MAX_BARS(MAX_BARS)) u_bsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .bar_i         (bar_i),
  .point_valid_o (point_valid_o),
  .point_o       (point_o)
);

// File: sim/tb_top.sv
// Self-checking testbench for barcode_stable_rank: directed bars, then random barcodes.
// Depends on bsr_pkg for the bar_t and point_t payload types and the RTL top level.
// An in-bench predictor computes the stable-rank points and every point is checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsr_pkg::*;

  localparam int unsigned MaxBars   = MaxBarsDefault;
  localparam int unsigned RandItems = 160;
  // Longest quiet stretch of a correct run is a full insertion or a full emission
  // plus a sender gap, so this limit leaves a wide margin.
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned TailCycles    = 40;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  bar_t   bar_i = '0;
  logic   busy_o;
  logic   point_valid_o;
  point_t point_o;

  always #4 clk_i = ~clk_i;

  barcode_stable_rank dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .bar_i        (bar_i),
    .point_valid_o(point_valid_o),
    .point_o      (point_o)
  );

  // Shadow of the block's barcode state, kept in step with every accepted bar.
  logic [ValueW-1:0] held_life [MaxBars];
  int unsigned held_finite = 0;
  int unsigned held_bars = 0;
  bit          bars_dropped = 1'b0;

  // Points the block still owes us, oldest first.
  point_t rank_points_q [$];

  int unsigned mismatches = 0;
  int unsigned points_checked = 0;
  int unsigned bars_sent = 0;
  int unsigned barcodes_done = 0;
  int unsigned overflow_barcodes = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;

  // One row of the directed stimulus. A row with typed points carries its own
  // expectation; every other row is left to the predictor.
  typedef struct {
    bar_t           bar;
    int unsigned    n_typed;
    point_t [1:0]   typed;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic point_t mk_point(logic [ValueW-1:0] pos, int unsigned rank,
                                      bit lastp, bit ovf);
    point_t p;
    p.step_position = pos;
    p.rank_value    = rank[RankW-1:0];
    p.last_point    = lastp;
    p.overflowed    = ovf;
    return p;
  endfunction

  function automatic bar_t mk_bar(logic [ValueW-1:0] birth, logic [ValueW-1:0] death,
                                  bit fin, bit lastb);
    bar_t b;
    b.birth_value     = birth;
    b.death_value     = death;
    b.death_is_finite = fin;
    b.last_bar        = lastb;
    return b;
  endfunction

  function automatic void add_row(bar_t b, int unsigned n, point_t p0, point_t p1);
    stim_row_t r;
    r.bar      = b;
    r.n_typed  = n;
    r.typed[0] = p0;
    r.typed[1] = p1;
    directed_rows.push_back(r);
  endfunction

  // Takes one accepted bar into the shadow state. On the last bar of a barcode it
  // sorts the lifetimes, works out the step function and, when asked, queues it.
  function automatic void absorb_bar(bar_t b, bit queue_points);
    logic [ValueW-1:0] srt [MaxBars];
    logic [ValueW-1:0] key;
    logic [ValueW-1:0] prev;
    point_t            pts [MaxBars+1];
    int unsigned       n, k, surv, i, j;

    if (held_bars < MaxBars) begin
      if (b.death_is_finite) begin
        // A death before the birth saturates the lifetime at zero.
        held_life[held_finite] = (b.death_value >= b.birth_value) ?
                                 b.death_value - b.birth_value : '0;
        held_finite++;
      end
      held_bars++;
    end else begin
      bars_dropped = 1'b1;
    end

    if (!b.last_bar) return;

    n = held_finite;
    for (i = 0; i < n; i++) srt[i] = held_life[i];
    for (i = 1; i < n; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end

    k = 0;
    pts[k] = mk_point('0, held_bars, 1'b0, bars_dropped);
    k++;
    if (n > 0) begin
      // Infinite bars never fall out, so they stay inside every rank.
      surv = held_bars;
      prev = srt[0];
      for (i = 0; i < n; i++) begin
        if (srt[i] != prev) begin
          pts[k] = mk_point(prev, surv, 1'b0, bars_dropped);
          k++;
          prev = srt[i];
        end
        surv--;
      end
      pts[k] = mk_point(prev, surv, 1'b0, bars_dropped);
      k++;
    end
    pts[k-1].last_point = 1'b1;

    if (queue_points) begin
      for (i = 0; i < k; i++) rank_points_q.push_back(pts[i]);
    end
    barcodes_done++;
    if (bars_dropped) overflow_barcodes++;
    held_finite  = 0;
    held_bars    = 0;
    bars_dropped = 1'b0;
  endfunction

  // Random bar. Half of the deaths sit a few whole units after the birth so that equal
  // lifetimes are common; some deaths are fully random or at or before the birth.
  function automatic bar_t rand_bar(int unsigned inf_pct, bit lastb);
    bar_t b;
    b.birth_value = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        b.death_value = $urandom;
      end
      3: begin
        b.death_value = b.birth_value - $urandom_range(0, 3);
      end
      default: begin
        b.death_value = b.birth_value + ($urandom_range(0, 4) << 16);
      end
    endcase
    b.death_is_finite = ($urandom_range(0, 99) >= inf_pct);
    b.last_bar        = lastb;
    return b;
  endfunction

  // Raises start with the bar and holds it until the block takes it. The transfer
  // happens at the edge where start is high and busy is low.
  task automatic send_bar(bar_t b, int unsigned n_typed, point_t [1:0] typed);
    start_i <= 1'b1;
    bar_i   <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    bars_sent++;
    absorb_bar(b, n_typed == 0);
    for (int unsigned i = 0; i < n_typed; i++) rank_points_q.push_back(typed[i]);
  endtask

  // Sender pacing: bursts of random length, random gaps between them, and now and
  // then a long burst with no gap at all. With drain set the sender also holds off
  // until every owed point has come back.
  task automatic pace(bit drain);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
      gap = $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
    if (drain && gap == 0) gap = 1;
    if (gap == 0) return;
    start_i <= 1'b0;
    bar_i   <= {$urandom, $urandom, 2'($urandom)};
    repeat (gap) @(posedge clk_i);
    while (drain && rank_points_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(string what, point_t want, point_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected pos=%h rank=%0d last=%b ovf=%b",
               $realtime, what, want.step_position, want.rank_value, want.last_point,
               want.overflowed);
      $display("    got pos=%h rank=%0d last=%b ovf=%b",
               got.step_position, got.rank_value, got.last_point, got.overflowed);
    end
  endtask

  // Result checker and watchdog. A point is on the ports for exactly one cycle and
  // the transfer is the edge that ends that cycle, so sampling at the edge sees it
  // once. The watchdog counts cycles with no transfer in either direction.
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni) begin
      if (point_valid_o === 1'b1) begin
        if (rank_points_q.size() == 0) begin
          note_mismatch("point with nothing owed", '0, point_o);
        end else begin
          want = rank_points_q.pop_front();
          points_checked++;
          if (point_o.step_position !== want.step_position ||
              point_o.rank_value    !== want.rank_value    ||
              point_o.last_point    !== want.last_point    ||
              point_o.overflowed    !== want.overflowed) begin
            note_mismatch("point mismatch", want, point_o);
          end
        end
      end
      if ((start_i && busy_o === 1'b0) || point_valid_o === 1'b1) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d points still owed",
                 idle_cycles, rank_points_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned code_idx;
    int unsigned code_len;
    int unsigned inf_pct;

    // Single-bar barcodes whose points can be written down directly: an infinite
    // bar alone, the widest lifetime, a death before its birth, a zero lifetime
    // and alternating bit patterns.
    add_row(mk_bar(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1), 1,
            mk_point('0, 1, 1'b1, 1'b0), '0);
    add_row(mk_bar(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1), 2,
            mk_point('0, 1, 1'b0, 1'b0), mk_point(32'hFFFF_FFFF, 0, 1'b1, 1'b0));
    add_row(mk_bar(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1), 2,
            mk_point('0, 1, 1'b0, 1'b0), mk_point('0, 0, 1'b1, 1'b0));
    add_row(mk_bar(32'h0001_8000, 32'h0001_8000, 1'b1, 1'b1), 2,
            mk_point('0, 1, 1'b0, 1'b0), mk_point('0, 0, 1'b1, 1'b0));
    add_row(mk_bar(32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b1, 1'b1), 2,
            mk_point('0, 1, 1'b0, 1'b0), mk_point(32'h5555_5555, 0, 1'b1, 1'b0));
    add_row(mk_bar(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1), 2,
            mk_point('0, 1, 1'b0, 1'b0), mk_point(32'h5555_5555, 0, 1'b1, 1'b0));
    // A mixed barcode: repeated lifetimes, an infinite bar whose death must be
    // ignored, a zero lifetime and a saturated one. The predictor covers it.
    add_row(mk_bar(32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h0000_0000, 32'h0003_0000, 1'b1, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b0, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h0005_0000, 32'h0006_0000, 1'b1, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h0007_0000, 32'h0007_0000, 1'b1, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h0009_0000, 32'h0008_0000, 1'b1, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h0000_0000, 32'h0002_0000, 1'b1, 1'b1), 0, '0, '0);
    // Only infinite bars: a single point carrying the bar count.
    add_row(mk_bar(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1), 1,
            mk_point('0, 4, 1'b1, 1'b0), '0);
    // A finite bar closed by an infinite last bar.
    add_row(mk_bar(32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0), 0, '0, '0);
    add_row(mk_bar(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1), 0, '0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_bar(directed_rows[i].bar, directed_rows[i].n_typed, directed_rows[i].typed);
      pace(i == directed_rows.size() - 1);
    end

    // Random barcodes. Most are short; three fill the store: one to exactly full,
    // one past full with mixed bars, and one past full with infinite bars only, so
    // the last bar itself is dropped and the rank reaches the capacity MaxBars.
    random_sent = 0;
    code_idx = 0;
    while (random_sent < RandItems) begin
      case (code_idx)
        2: begin
          code_len = MaxBars + 2;
          inf_pct  = 20;
        end
        6: begin
          code_len = MaxBars;
          inf_pct  = 0;
        end
        10: begin
          code_len = MaxBars + 1;
          inf_pct  = 100;
        end
        default: begin
          code_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 8);
          inf_pct  = 20;
        end
      endcase
      for (int unsigned i = 0; i < code_len; i++) begin
        send_bar(rand_bar(inf_pct, i == code_len - 1), 0, '0);
        random_sent++;
        pace(code_idx == 5 && i == code_len - 1);
      end
      code_idx++;
    end

    // Let the last barcode finish emitting, then keep the clock running
    // so that any stray point still shows.
    start_i <= 1'b0;
    while (rank_points_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d bars in %0d barcodes, %0d of them with dropped bars.",
             bars_sent, barcodes_done, overflow_barcodes);
    $display("%0d points checked, %0d mismatches.", points_checked, mismatches);
    if (mismatches == 0 && rank_points_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bsr_pkg.sv
hw/rtl/bsr_alu.sv
hw/rtl/barcode_stable_rank.sv
hw/rtl/bsr_checker.sv
sim/tb_top.sv
